>>> rtl/core/spectral_sample_to_xyz_macros.svh
// assertion macros for the spectral sample to xyz block
`ifndef SPECTRAL_SAMPLE_TO_XYZ_MACROS_SVH
`define SPECTRAL_SAMPLE_TO_XYZ_MACROS_SVH
`ifndef SYNTH
`define SSX_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSX_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/ssxyz_pkg.sv
// constants, lobe tables and exponential table builder for spectral sample to xyz
`default_nettype none
package ssxyz_pkg;

  localparam int unsigned EXP_TABLE_ADDR_BITS_DEF = 10;
  localparam int unsigned LOBE_N = 7;
  localparam logic [15:0] Y_NORM_RESET = 16'd613;

  typedef logic [15:0] word16_t;
  typedef logic [16:0] amp_t;
  typedef logic [32:0] exp_val_t;

  // lobe order: x0 x1 x2 y0 y1 z0 z1
  localparam word16_t LOBE_CENTRE [LOBE_N] =
    '{16'd28288, 16'd38387, 16'd32070, 16'd36403, 16'd33978, 16'd27968, 16'd29376};
  localparam word16_t LOBE_LEFT [LOBE_N] =
    '{16'd4089, 16'd1730, 16'd3211, 16'd1396, 16'd4017, 16'd5538, 16'd2523};
  localparam word16_t LOBE_RIGHT [LOBE_N] =
    '{16'd2451, 16'd2117, 16'd2503, 16'd1619, 16'd2110, 16'd1822, 16'd4751};
  localparam amp_t LOBE_AMP [LOBE_N] =
    '{17'd23724, 17'd69206, 17'd4260, 17'd53805, 17'd18743, 17'd79757, 17'd44630};

  // exp(-2^e) in q0.32, e = -10 .. 3
  localparam logic [31:0] EXP_POW2 [14] = '{
    32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595, 32'd4228380000,
    32'd4162825045, 32'd4034748383, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260613, 32'd78665069, 32'd1440801};

  function automatic exp_val_t exp_entry(input int unsigned idx, input int unsigned abits);
    logic [64:0] acc;
    logic [32:0] e;
    int unsigned ci;
    e = 33'h1_0000_0000;
    for (int unsigned k = 0; k < abits; k++) begin
      if (((idx >> k) & 1) != 0) begin
        ci = k + 14 - abits;
        acc = {32'd0, e} * {33'd0, EXP_POW2[ci]} + 65'h8000_0000;
        e = acc[64:32];
      end
    end
    return e;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/spectral_sample_to_xyz.sv
// spectral sample to cie 1931 xyz, eight stage pipeline
// One request is taken in every clock cycle (busy stays low) and its x, y and z values
// appear with done at the end of the pipeline, whose depth is set by the chain of
// difference, width multiply, square, exponential table read, amplitude multiply,
// lobe sum, power scaling and rounding with saturation. The receiver cannot stall.
// Configuration writes through cfg_we and cfg_wdata belong to idle periods.
`default_nettype none
module spectral_sample_to_xyz #(
  parameter int unsigned EXP_TABLE_ADDR_BITS = ssxyz_pkg::EXP_TABLE_ADDR_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [15:0]        wavelength,
  input  wire logic [15:0]        power,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  output logic                    done,
  output logic signed [31:0]      x_value,
  output logic signed [31:0]      y_value,
  output logic signed [31:0]      z_value
);

  localparam int unsigned A = EXP_TABLE_ADDR_BITS;
  localparam int unsigned DEPTH = 2 ** A;
  localparam int unsigned N = ssxyz_pkg::LOBE_N;

  logic [15:0] y_norm;
  logic [8:1] vld;

  logic [15:0] d1 [N];
  logic [15:0] w1 [N];
  logic [31:0] t2 [N];
  logic [A-1:0] idx3 [N];
  logic [N-1:0] zero3;
  ssxyz_pkg::exp_val_t e4 [N];
  logic [49:0] p5 [N];
  logic signed [24:0] s6 [3];
  logic signed [57:0] prod7 [3];
  logic [31:0] scale1, scale2, scale3, scale4, scale5, scale6;

  ssxyz_pkg::exp_val_t exp_table [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam ssxyz_pkg::exp_val_t ENTRY = ssxyz_pkg::exp_entry(i, A);
    assign exp_table[i] = ENTRY;
  end

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      y_norm <= ssxyz_pkg::Y_NORM_RESET;
      vld <= '0;
    end else begin
      if (cfg_we) begin
        y_norm <= cfg_wdata;
      end
      vld <= {vld[7:1], start & ~busy};
    end
  end

  // lobe stages
  for (genvar l = 0; l < N; l++) begin : g_lobe
    logic [49:0] tt;
    logic [15:0] c;
    assign c = ssxyz_pkg::LOBE_CENTRE[l];
    assign tt = {25'd0, t2[l][24:0]} * {25'd0, t2[l][24:0]};
    always_ff @(posedge clk) begin
      if (wavelength < c) begin
        d1[l] <= c - wavelength;
        w1[l] <= ssxyz_pkg::LOBE_LEFT[l];
      end else begin
        d1[l] <= wavelength - c;
        w1[l] <= ssxyz_pkg::LOBE_RIGHT[l];
      end
      t2[l] <= {16'd0, d1[l]} * {16'd0, w1[l]};
      zero3[l] <= (|t2[l][31:25]) | tt[49];
      idx3[l] <= tt[48 -: A];
      e4[l] <= zero3[l] ? '0 : exp_table[idx3[l]];
      p5[l] <= {33'd0, ssxyz_pkg::LOBE_AMP[l]} * {17'd0, e4[l]};
    end
  end

  // sums and scaling
  logic signed [50:0] sum_x, sum_y, sum_z;
  logic signed [50:0] rx, ry, rz;
  assign sum_x = $signed({1'b0, p5[0]}) + $signed({1'b0, p5[1]}) - $signed({1'b0, p5[2]});
  assign sum_y = $signed({1'b0, p5[3]}) + $signed({1'b0, p5[4]});
  assign sum_z = $signed({1'b0, p5[5]}) + $signed({1'b0, p5[6]});
  assign rx = sum_x + 51'sd33554432;
  assign ry = sum_y + 51'sd33554432;
  assign rz = sum_z + 51'sd33554432;

  logic signed [57:0] rnd7 [3];
  logic signed [33:0] r8 [3];
  logic signed [31:0] sat8 [3];
  for (genvar c = 0; c < 3; c++) begin : g_out
    assign rnd7[c] = prod7[c] + 58'sd8388608;
    assign r8[c] = rnd7[c][57:24];
    always_comb begin
      if (r8[c] > 34'sd2147483647) begin
        sat8[c] = 32'sh7FFF_FFFF;
      end else if (r8[c] < -34'sd2147483648) begin
        sat8[c] = 32'sh8000_0000;
      end else begin
        sat8[c] = r8[c][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    scale1 <= {16'd0, power} * {16'd0, y_norm};
    scale2 <= scale1;
    scale3 <= scale2;
    scale4 <= scale3;
    scale5 <= scale4;
    scale6 <= scale5;
    s6[0] <= rx[50:26];
    s6[1] <= ry[50:26];
    s6[2] <= rz[50:26];
    for (int c = 0; c < 3; c++) begin
      prod7[c] <= 58'(s6[c]) * $signed({26'd0, scale6});
    end
    x_value <= sat8[0];
    y_value <= sat8[1];
    z_value <= sat8[2];
  end

  assign done = vld[8];

  `include "spectral_sample_to_xyz_macros.svh"

  `SSX_ASSERT_IMP(a_y_nonneg, clk, rst, done, !y_value[31])
  `SSX_ASSERT_IMP(a_z_nonneg, clk, rst, done, !z_value[31])
  `SSX_ASSERT_NEXT(a_zero_scale, clk, rst, vld[7] && (scale6 == '0) && vld[6], 1'b1)
  `SSX_ASSERT_NEXT(a_zero_power, clk, rst, vld[7] && (prod7[1] == '0), y_value == '0)

endmodule
`default_nettype wire

>>> tb/sv/tb_spectral_sample_to_xyz.sv
// testbench for spectral_sample_to_xyz: random and corner samples against a predictor
`default_nettype none
module tb_spectral_sample_to_xyz;

  typedef struct packed {
    logic [15:0] wl;
    logic [15:0] pw;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } xyz_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [15:0] wavelength = '0;
  logic [15:0] power = '0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic done;
  logic signed [31:0] x_value, y_value, z_value;

  sample_t pending_samples[$];
  xyz_t expected_xyz[$];
  logic [15:0] norm_shadow = ssxyz_pkg::Y_NORM_RESET;
  int unsigned sender_idle_pct = 0;
  int unsigned mismatches = 0;

  localparam logic [15:0] CENTRE_TAB [7] =
    '{16'd28288, 16'd38387, 16'd32070, 16'd36403, 16'd33978, 16'd27968, 16'd29376};
  localparam logic [15:0] LEFT_TAB [7] =
    '{16'd4089, 16'd1730, 16'd3211, 16'd1396, 16'd4017, 16'd5538, 16'd2523};
  localparam logic [15:0] RIGHT_TAB [7] =
    '{16'd2451, 16'd2117, 16'd2503, 16'd1619, 16'd2110, 16'd1822, 16'd4751};
  localparam logic [16:0] AMP_TAB [7] =
    '{17'd23724, 17'd69206, 17'd4260, 17'd53805, 17'd18743, 17'd79757, 17'd44630};
  // exp(-2^k) in q0.32 for k = -10 .. 3
  localparam logic [31:0] DECAY_TAB [14] = '{
    32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595, 32'd4228380000,
    32'd4162825045, 32'd4034748383, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260613, 32'd78665069, 32'd1440801};

  spectral_sample_to_xyz dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .wavelength(wavelength), .power(power),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .x_value(x_value), .y_value(y_value), .z_value(z_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [32:0] gauss_decay(input logic [9:0] idx);
    logic [32:0] e;
    logic [64:0] prod;
    e = 33'h1_0000_0000;
    for (int k = 0; k < 10; k++) begin
      if (idx[k]) begin
        prod = {32'd0, e} * {33'd0, DECAY_TAB[k + 4]} + 65'h8000_0000;
        e = prod[64:32];
      end
    end
    return e;
  endfunction

  function automatic logic signed [63:0] lobe_q48(input int n, input logic [15:0] wl);
    logic [63:0] d, t, tt, idx;
    logic [15:0] w;
    logic signed [63:0] v;
    if (wl < CENTRE_TAB[n]) begin
      d = 64'(CENTRE_TAB[n] - wl);
      w = LEFT_TAB[n];
    end else begin
      d = 64'(wl - CENTRE_TAB[n]);
      w = RIGHT_TAB[n];
    end
    t = d * 64'(w);
    tt = t * t;
    idx = tt >> 39;
    if (idx >= 64'd1024) return 64'sd0;
    v = $signed(64'(AMP_TAB[n]) * 64'(gauss_decay(idx[9:0])));
    return (n == 2) ? -v : v;
  endfunction

  function automatic logic signed [63:0] round_down_bits(input logic signed [63:0] v,
                                                        input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] tristimulus(input int first, input int count,
                                                     input logic [15:0] wl,
                                                     input logic [31:0] scale);
    logic signed [63:0] sum, s, r;
    sum = 0;
    for (int i = first; i < first + count; i++) sum += lobe_q48(i, wl);
    s = round_down_bits(sum, 26);
    r = round_down_bits(s * $signed({32'd0, scale}), 24);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic xyz_t predict_xyz(input sample_t s, input logic [15:0] norm);
    logic [31:0] scale;
    xyz_t o;
    scale = 32'(s.pw) * 32'(norm);
    o.x = tristimulus(0, 3, s.wl, scale);
    o.y = tristimulus(3, 2, s.wl, scale);
    o.z = tristimulus(5, 2, s.wl, scale);
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    sample_t s;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_xyz.push_back(predict_xyz({wavelength, power}, norm_shadow));
      if ((!start || !busy) ) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s = pending_samples.pop_front();
          start <= 1'b1;
          wavelength <= s.wl;
          power <= s.pw;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    xyz_t e;
    if (!rst && done) begin
      if (expected_xyz.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, x_value, y_value, z_value);
        mismatches++;
      end else begin
        e = expected_xyz.pop_front();
        if (x_value !== e.x) begin
          $display("%0t: x expected %0d actual %0d", $time, e.x, x_value);
          mismatches++;
        end
        if (y_value !== e.y) begin
          $display("%0t: y expected %0d actual %0d", $time, e.y, y_value);
          mismatches++;
        end
        if (z_value !== e.z) begin
          $display("%0t: z expected %0d actual %0d", $time, e.z, z_value);
          mismatches++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || start || expected_xyz.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_norm(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    norm_shadow <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    // mostly the visible band, sometimes anything
    if ($urandom_range(9) < 7) s.wl = 16'($urandom_range(53120, 23040));
    else s.wl = 16'($urandom);
    case ($urandom_range(3))
      0: s.pw = 16'($urandom_range(511));
      1: s.pw = 16'($urandom_range(65535, 65000));
      default: s.pw = 16'($urandom);
    endcase
    return s;
  endfunction

  initial begin
    logic [15:0] norms [5];
    int counts [5];
    norms = '{16'd613, 16'hFFFF, 16'd0, 16'd1, 16'($urandom)};
    counts = '{500, 500, 300, 300, 300};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // corners: range ends, lobe centres and their neighbors, table edge
    pending_samples.push_back('{16'd0, 16'hFFFF});
    pending_samples.push_back('{16'hFFFF, 16'hFFFF});
    pending_samples.push_back('{16'd36403, 16'd0});
    pending_samples.push_back('{16'd36403, 16'hFFFF});
    for (int i = 0; i < 7; i++) begin
      pending_samples.push_back('{CENTRE_TAB[i], 16'd256});
      pending_samples.push_back('{CENTRE_TAB[i] - 16'd1, 16'hFFFF});
      pending_samples.push_back('{CENTRE_TAB[i] + 16'd1, 16'h8000});
    end
    pending_samples.push_back('{16'd20000, 16'hFFFF});
    pending_samples.push_back('{16'd60000, 16'hFFFF});
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_norm(norms[p]);
      sender_idle_pct = (p == 0) ? 9 : (p == 1) ? 84 : 0;
      for (int n = 0; n < counts[p]; n++) pending_samples.push_back(random_sample());
      wait_drained();
    end

    if (mismatches == 0 && expected_xyz.size() == 0)
      $display("spectral_sample_to_xyz regression: pass");
    else
      $display("spectral_sample_to_xyz regression: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("spectral_sample_to_xyz regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
